// ===== design/first_fit_heap_stack_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap and stack allocator
// Shared property forms used by the assertions at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_STACK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_STACK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFHSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFHSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ffhsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffhsa_pkg
// Types, widths and codes shared by the allocator controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffhsa_pkg;

	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int ADDR_W    = 21;
	localparam int POS_W     = 22;
	localparam int LEN_W     = 16;
	localparam int ID_W      = 32;
	localparam int OP_W      = 2;
	localparam int ST_W      = 3;

	localparam int MAX_CHUNKS_D = 64;
	localparam int MAX_STACK_D  = 32;

	localparam logic [CFG_W-1:0] HEAP_RST  = 20'd65536;
	localparam logic [CFG_W-1:0] STACK_RST = 20'd16384;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STACK = 2'd1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_PUSH  = 2'd2,
		OP_POP   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_NOSPACE  = 3'd1,
		ST_TBLFULL  = 3'd2,
		ST_UNKNOWN  = 3'd3,
		ST_STKEMPTY = 3'd4
	} st_t;

	// Datapath actions issued by the controller, one per cycle.
	typedef enum logic [3:0] {
		A_NONE,
		A_LOAD,
		A_SCAN,
		A_RD,
		A_MOVE,
		A_INS_PUT,
		A_REM_DONE,
		A_PUSH,
		A_SRD,
		A_POP,
		A_FAIL
	} act_t;

	typedef struct packed {
		act_t act;
		st_t  err;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic tbl_full;
		logic stk_full;
		logic stk_empty;
		logic heap_fit;
		logic push_fit;
		logic match;
		logic gt;
	} stat_t;

endpackage

// ===== design/first_fit_heap_stack_allocator.sv =====
// Pop reads the stack top; push, allocate and free first walk the whole chunk table,
// and allocate and free then shift list entries one place each. A refusal comes
// either before the walk or after it.
// The walk of the chunk table reads one entry per cycle.
// One item at a time: a new request is taken at the edge that ends the done beat.
// Reset clears the table, stack and handle counter; sizes return to their defaults.
// ----------------------------------------------------------------------------
// first_fit_heap_stack_allocator
// First-fit heap allocator with a LIFO stack part over one byte region.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_heap_stack_allocator_defines.svh"

module first_fit_heap_stack_allocator #(
	parameter int MAX_CHUNKS = ffhsa_pkg::MAX_CHUNKS_D,
	parameter int MAX_STACK  = ffhsa_pkg::MAX_STACK_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ffhsa_pkg::OP_W-1:0]      op,
	input  logic [ffhsa_pkg::LEN_W-1:0]     req_size,
	input  logic [ffhsa_pkg::ID_W-1:0]      free_handle,
	output logic                            done,
	output logic [ffhsa_pkg::ST_W-1:0]      status,
	output logic [ffhsa_pkg::ID_W-1:0]      handle,
	output logic [ffhsa_pkg::ADDR_W-1:0]    start_addr,
	input  logic                            cfg_we,
	input  logic [ffhsa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ffhsa_pkg::CFG_W-1:0]     cfg_wdata
);
	import ffhsa_pkg::*;

	localparam int CW = $clog2(MAX_CHUNKS);
	localparam int HW = $clog2(MAX_CHUNKS + 1);

	// The controller steps through the request; the datapath holds all state.
	// Heap chunks sit in a memory kept sorted by start address, so the first
	// fit search is one linear walk. An allocation opens a hole by moving the
	// larger entries up one place; a free closes the hole the same way.
	cmd_t          cmd;
	stat_t         stat;
	logic [CW-1:0] addr;
	logic [HW-1:0] hn;
	logic [CW-1:0] midx;

	ffhsa_ctl #(
		.MAX_CHUNKS(MAX_CHUNKS)
	) u_ctl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.stat  (stat),
		.hn    (hn),
		.midx  (midx),
		.cmd   (cmd),
		.addr  (addr)
	);

	ffhsa_dp #(
		.MAX_CHUNKS(MAX_CHUNKS),
		.MAX_STACK (MAX_STACK)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.req_size   (req_size),
		.free_handle(free_handle),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.addr       (addr),
		.stat       (stat),
		.hn         (hn),
		.midx       (midx),
		.status     (status),
		.handle     (handle),
		.start_addr (start_addr)
	);

	// A done beat is always a single cycle and arrives with the block idle.
	`FFHSA_ASSERT_NEXT(a_done_single, done, !done, "done beat lasted more than one cycle")
	`FFHSA_ASSERT_NOW(a_done_idle, done, !busy, "done beat while still busy")
	// An accepted request always makes the block busy in the next cycle.
	`FFHSA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request left block idle")
	// Failed requests report a zero handle and address.
	`FFHSA_ASSERT_NOW(a_err_zero, done && (status != ST_OK),
		(handle == '0) && (start_addr == '0), "error result carries nonzero payload")

endmodule

// ===== design/ffhsa_dp.sv =====
// ----------------------------------------------------------------------------
// ffhsa_dp
// Datapath: sorted heap chunk list, stack memory, occupancy and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffhsa_dp #(
	parameter int MAX_CHUNKS = ffhsa_pkg::MAX_CHUNKS_D,
	parameter int MAX_STACK  = ffhsa_pkg::MAX_STACK_D,
	localparam int CW = $clog2(MAX_CHUNKS),
	localparam int HW = $clog2(MAX_CHUNKS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ffhsa_pkg::OP_W-1:0]      op,
	input  logic [ffhsa_pkg::LEN_W-1:0]     req_size,
	input  logic [ffhsa_pkg::ID_W-1:0]      free_handle,
	input  logic                            cfg_we,
	input  logic [ffhsa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ffhsa_pkg::CFG_W-1:0]     cfg_wdata,
	input  ffhsa_pkg::cmd_t                 cmd,
	input  logic [CW-1:0]                   addr,
	output ffhsa_pkg::stat_t                stat,
	output logic [HW-1:0]                   hn,
	output logic [CW-1:0]                   midx,
	output logic [ffhsa_pkg::ST_W-1:0]      status,
	output logic [ffhsa_pkg::ID_W-1:0]      handle,
	output logic [ffhsa_pkg::ADDR_W-1:0]    start_addr
);
	import ffhsa_pkg::*;

	localparam int SAW = (MAX_STACK > 1) ? $clog2(MAX_STACK) : 1;
	localparam int DW  = $clog2(MAX_STACK + 1);

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
		logic [ID_W-1:0]   id;
		logic [CW-1:0]     slot;
	} ent_t;

	// Heap chunks kept in (start, slot) order; stacked chunks live apart.
	ent_t lst [MAX_CHUNKS];
	ent_t stk_mem [MAX_STACK];
	ent_t rd_q, srd_q, new_ent, push_ent;

	logic [CFG_W-1:0]      heap_q, stk_q;
	logic [ADDR_W-1:0]     sp_q;
	logic [ID_W-1:0]       next_id_q;
	logic [MAX_CHUNKS-1:0] used_q;
	logic [HW-1:0]         cnt_q, hn_q;
	logic [DW-1:0]         depth_q, depth_m1;
	op_t                   op_q;
	logic [LEN_W-1:0]      size_q;
	logic [ID_W-1:0]       fh_q;
	logic [POS_W-1:0]      pos_q;
	logic                  found_q, have_fs_q, match_q, ev_q;
	logic [CW-1:0]         fs_q, midx_q, mslot_q, eidx_q;
	logic [ADDR_W-1:0]     mstart_q;
	st_t                   res_st_q;
	logic [ID_W-1:0]       res_id_q;
	logic [ADDR_W-1:0]     res_addr_q;

	logic [POS_W-1:0]  s_ext, end_ext, heap_ext;
	logic [ADDR_W-1:0] top, sp_pop;
	logic              gap_ok;

	always_comb begin
		new_ent  = '{start: pos_q[ADDR_W-1:0], len: size_q, id: next_id_q, slot: fs_q};
		push_ent = '{start: sp_q, len: size_q, id: next_id_q, slot: fs_q};
		s_ext    = POS_W'(rd_q.start);
		end_ext  = s_ext + POS_W'(rd_q.len);
		gap_ok   = (s_ext > pos_q) && (POS_W'(size_q) < (s_ext - pos_q));
		heap_ext = POS_W'(heap_q);
		top      = ADDR_W'(heap_q) + ADDR_W'(stk_q);
		sp_pop   = (ADDR_W'(srd_q.len) > sp_q) ? '0 : sp_q - ADDR_W'(srd_q.len);
		depth_m1 = depth_q - DW'(1);

		stat.op        = op_q;
		stat.tbl_full  = (cnt_q == HW'(MAX_CHUNKS));
		stat.stk_full  = (depth_q >= DW'(MAX_STACK));
		stat.stk_empty = (depth_q == '0);
		stat.heap_fit  = found_q ||
			((pos_q <= heap_ext) && (POS_W'(size_q) <= (heap_ext - pos_q)));
		stat.push_fit  = (sp_q <= top) && (ADDR_W'(size_q) <= (top - sp_q));
		stat.match     = match_q;
		stat.gt        = (s_ext > pos_q) || ((s_ext == pos_q) && (rd_q.slot > fs_q));
	end

	assign hn         = hn_q;
	assign midx       = midx_q;
	assign status     = res_st_q;
	assign handle     = res_id_q;
	assign start_addr = res_addr_q;

	// Memories: one read and one write port each, read data registered.
	always_ff @(posedge clk) begin
		if (cmd.act == A_SCAN || cmd.act == A_RD) begin
			rd_q <= lst[addr];
		end
		if (cmd.act == A_MOVE) begin
			lst[addr] <= rd_q;
		end else if (cmd.act == A_INS_PUT) begin
			lst[addr] <= new_ent;
		end
		if (cmd.act == A_PUSH) begin
			stk_mem[depth_q[SAW-1:0]] <= push_ent;
		end
		if (cmd.act == A_SRD) begin
			srd_q <= stk_mem[depth_m1[SAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.act)
			A_INS_PUT: begin
				res_st_q   <= ST_OK;
				res_id_q   <= next_id_q;
				res_addr_q <= pos_q[ADDR_W-1:0];
			end
			A_REM_DONE: begin
				res_st_q   <= ST_OK;
				res_id_q   <= fh_q;
				res_addr_q <= mstart_q;
			end
			A_PUSH: begin
				res_st_q   <= ST_OK;
				res_id_q   <= next_id_q;
				res_addr_q <= sp_q;
			end
			A_POP: begin
				res_st_q   <= ST_OK;
				res_id_q   <= srd_q.id;
				res_addr_q <= srd_q.start;
			end
			A_FAIL: begin
				res_st_q   <= cmd.err;
				res_id_q   <= '0;
				res_addr_q <= '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q    <= HEAP_RST;
			stk_q     <= STACK_RST;
			sp_q      <= ADDR_W'(HEAP_RST);
			next_id_q <= '0;
			used_q    <= '0;
			cnt_q     <= '0;
			hn_q      <= '0;
			depth_q   <= '0;
			op_q      <= OP_ALLOC;
			size_q    <= '0;
			fh_q      <= '0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			fs_q      <= '0;
			have_fs_q <= 1'b0;
			match_q   <= 1'b0;
			midx_q    <= '0;
			mslot_q   <= '0;
			mstart_q  <= '0;
			ev_q      <= 1'b0;
			eidx_q    <= '0;
		end else begin
			// Registers change only while no chunk is live.
			if (cfg_we && cnt_q == '0) begin
				if (cfg_idx == REG_HEAP) begin
					heap_q <= cfg_wdata;
					sp_q   <= ADDR_W'(cfg_wdata);
				end else if (cfg_idx == REG_STACK) begin
					stk_q <= cfg_wdata;
				end
			end

			// Evaluate the list entry read in the previous scan cycle.
			if (ev_q) begin
				if (op_q == OP_ALLOC && !found_q) begin
					if (gap_ok) begin
						found_q <= 1'b1;
					end else begin
						pos_q <= end_ext;
					end
				end
				if (op_q == OP_FREE && rd_q.id == fh_q &&
					(!match_q || rd_q.slot < mslot_q)) begin
					match_q  <= 1'b1;
					midx_q   <= eidx_q;
					mslot_q  <= rd_q.slot;
					mstart_q <= rd_q.start;
				end
			end

			unique case (cmd.act)
				A_LOAD: begin
					op_q      <= op_t'(op);
					size_q    <= req_size;
					fh_q      <= free_handle;
					pos_q     <= '0;
					found_q   <= 1'b0;
					have_fs_q <= 1'b0;
					match_q   <= 1'b0;
				end
				A_SCAN: begin
					if (!have_fs_q && !used_q[addr]) begin
						fs_q      <= addr;
						have_fs_q <= 1'b1;
					end
				end
				A_INS_PUT: begin
					used_q[fs_q] <= 1'b1;
					cnt_q        <= cnt_q + HW'(1);
					hn_q         <= hn_q + HW'(1);
					next_id_q    <= next_id_q + ID_W'(1);
				end
				A_REM_DONE: begin
					used_q[mslot_q] <= 1'b0;
					cnt_q           <= cnt_q - HW'(1);
					hn_q            <= hn_q - HW'(1);
				end
				A_PUSH: begin
					used_q[fs_q] <= 1'b1;
					cnt_q        <= cnt_q + HW'(1);
					depth_q      <= depth_q + DW'(1);
					sp_q         <= sp_q + ADDR_W'(size_q);
					next_id_q    <= next_id_q + ID_W'(1);
				end
				A_POP: begin
					used_q[srd_q.slot] <= 1'b0;
					cnt_q              <= cnt_q - HW'(1);
					depth_q            <= depth_m1;
					sp_q               <= sp_pop;
				end
				default: ;
			endcase

			ev_q   <= (cmd.act == A_SCAN) && (HW'(addr) < hn_q);
			eidx_q <= addr;
		end
	end

endmodule

// ===== design/ffhsa_ctl.sv =====
// ----------------------------------------------------------------------------
// ffhsa_ctl
// Controller: sequences the scan, insert shift, remove shift and stack steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffhsa_ctl #(
	parameter int MAX_CHUNKS = ffhsa_pkg::MAX_CHUNKS_D,
	localparam int CW = $clog2(MAX_CHUNKS),
	localparam int HW = $clog2(MAX_CHUNKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	input  ffhsa_pkg::stat_t stat,
	input  logic [HW-1:0]    hn,
	input  logic [CW-1:0]    midx,
	output ffhsa_pkg::cmd_t  cmd,
	output logic [CW-1:0]    addr
);
	import ffhsa_pkg::*;

	localparam int XW = CW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SCAN, S_DRAIN, S_DECIDE,
		S_INS_RD, S_INS_WR, S_REM_RD, S_REM_WR, S_POP_RD, S_POP_WR
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic          fin;
	logic [XW-1:0] idx_inc;

	assign busy    = (state_q != S_IDLE);
	assign idx_inc = XW'(idx_q) + XW'(1);

	// The address bus carries the read address during the read steps:
	// the entry below the hole on insert, the entry above it on remove.
	always_comb begin
		addr = idx_q;
		if (state_q == S_INS_RD && idx_q != '0) begin
			addr = idx_q - CW'(1);
		end else if (state_q == S_REM_RD) begin
			addr = idx_inc[CW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		fin     = 1'b0;
		cmd     = '{act: A_NONE, err: ST_OK};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.act = A_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				idx_d = '0;
				unique case (stat.op)
					OP_ALLOC: begin
						if (stat.tbl_full) begin
							cmd = '{act: A_FAIL, err: ST_TBLFULL};
							fin = 1'b1;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_FREE: state_d = S_SCAN;
					OP_PUSH: begin
						if (stat.tbl_full || stat.stk_full) begin
							cmd = '{act: A_FAIL, err: ST_TBLFULL};
							fin = 1'b1;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_POP: begin
						if (stat.stk_empty) begin
							cmd = '{act: A_FAIL, err: ST_STKEMPTY};
							fin = 1'b1;
						end else begin
							state_d = S_POP_RD;
						end
					end
				endcase
			end
			S_SCAN: begin
				cmd.act = A_SCAN;
				if (idx_q == CW'(MAX_CHUNKS - 1)) begin
					state_d = S_DRAIN;
				end else begin
					idx_d = idx_q + CW'(1);
				end
			end
			S_DRAIN: state_d = S_DECIDE;
			S_DECIDE: begin
				unique case (stat.op)
					OP_ALLOC: begin
						if (stat.heap_fit) begin
							idx_d   = CW'(hn);
							state_d = S_INS_RD;
						end else begin
							cmd = '{act: A_FAIL, err: ST_NOSPACE};
							fin = 1'b1;
						end
					end
					OP_FREE: begin
						if (stat.match) begin
							idx_d   = midx;
							state_d = S_REM_RD;
						end else begin
							cmd = '{act: A_FAIL, err: ST_UNKNOWN};
							fin = 1'b1;
						end
					end
					OP_PUSH: begin
						if (stat.push_fit) begin
							cmd.act = A_PUSH;
						end else begin
							cmd = '{act: A_FAIL, err: ST_NOSPACE};
						end
						fin = 1'b1;
					end
					OP_POP: state_d = S_IDLE;
				endcase
			end
			S_INS_RD: begin
				if (idx_q == '0) begin
					cmd.act = A_INS_PUT;
					fin     = 1'b1;
				end else begin
					cmd.act = A_RD;
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				if (stat.gt) begin
					cmd.act = A_MOVE;
					idx_d   = idx_q - CW'(1);
					state_d = S_INS_RD;
				end else begin
					cmd.act = A_INS_PUT;
					fin     = 1'b1;
				end
			end
			S_REM_RD: begin
				if (idx_inc >= XW'(hn)) begin
					cmd.act = A_REM_DONE;
					fin     = 1'b1;
				end else begin
					cmd.act = A_RD;
					state_d = S_REM_WR;
				end
			end
			S_REM_WR: begin
				cmd.act = A_MOVE;
				idx_d   = idx_inc[CW-1:0];
				state_d = S_REM_RD;
			end
			S_POP_RD: begin
				cmd.act = A_SRD;
				state_d = S_POP_WR;
			end
			S_POP_WR: begin
				cmd.act = A_POP;
				fin     = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= fin;
			idx_q   <= idx_d;
		end
	end

endmodule
